// ----- src/gtm_pkg.sv -----
`timescale 1ns / 1ps

package gtm_pkg;

  localparam int MAX_BLOCK = 4096;

  localparam logic [12:0] BLOCK_MIN = 13'd2;
  localparam logic [12:0] BLOCK_MAX = 13'(MAX_BLOCK);

  localparam logic [12:0] BLOCK_RESET = 13'd205;
  localparam logic signed [15:0] COS_RESET = 16'sd0;
  localparam logic signed [15:0] SIN_RESET = 16'sd16384;

  // Scaled component cap, 2^25
  localparam logic [25:0] QUOT_CAP = 26'h2000000;

  localparam int ROOT_STEPS = 26;
  localparam int QUOT_STEPS = 26;

  localparam logic [1:0] CFG_COS   = 2'd0;
  localparam logic [1:0] CFG_SIN   = 2'd1;
  localparam logic [1:0] CFG_BLOCK = 2'd2;

  typedef enum logic [2:0] {
    MS_COS_S1,
    MS_COS_S2,
    MS_SIN_S2,
    MS_RE_SQ,
    MS_IM_SQ
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_LOAD_S1,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic     load_x;
    mul_sel_t mul_sel;
    logic [1:0] mul_k;
    acc_op_t  acc_op;
    logic     update;
    logic     div_start;
    logic     store_re;
    logic     store_im;
    logic     sqrt_start;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } sts_t;

endpackage

// ----- src/gtm_div.sv -----
`timescale 1ns / 1ps

module gtm_div import gtm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [64:0] dividend,
  input  logic [12:0]        divisor,
  output logic               done,
  output logic [25:0]        quotient
);

  typedef enum logic [2:0] {
    D_IDLE,
    D_PREP,
    D_CHECK,
    D_ITER,
    D_FIN
  } dstate_t;

  dstate_t     state;
  logic [63:0] num;
  logic [25:0] lo;
  logic [12:0] rem;
  logic [25:0] q;
  logic [4:0]  cnt;

  logic [64:0] neg;
  logic [63:0] a_abs;
  logic [63:0] sum;
  logic [32:0] hi;
  logic [13:0] rem2;
  logic [13:0] rem_sub;

  always_comb begin
    neg     = -dividend;
    a_abs   = dividend[64] ? neg[63:0] : dividend[63:0];
    // rounding offset d/2 with d = 32*N
    sum     = num + {47'd0, divisor, 4'd0};
    hi      = num[58:26];
    rem2    = {rem, lo[25]};
    rem_sub = rem2 - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (start) begin
            num   <= a_abs;
            state <= D_PREP;
          end
        end
        D_PREP: begin
          num   <= {5'd0, sum[63:5]};
          state <= D_CHECK;
        end
        D_CHECK: begin
          if (hi >= {20'd0, divisor}) begin
            q     <= QUOT_CAP;
            state <= D_FIN;
          end else begin
            rem   <= hi[12:0];
            lo    <= num[25:0];
            q     <= '0;
            cnt   <= 5'(QUOT_STEPS);
            state <= D_ITER;
          end
        end
        D_ITER: begin
          if (rem2 >= {1'b0, divisor}) begin
            rem <= rem_sub[12:0];
            q   <= {q[24:0], 1'b1};
          end else begin
            rem <= rem2[12:0];
            q   <= {q[24:0], 1'b0};
          end
          lo  <= {lo[24:0], 1'b0};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign done     = (state == D_FIN);
  assign quotient = (q > QUOT_CAP) ? QUOT_CAP : q;

endmodule

// ----- src/gtm_sqrt.sv -----
`timescale 1ns / 1ps

module gtm_sqrt import gtm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [51:0] radicand,
  output logic        done,
  output logic [25:0] root
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ITER,
    S_FIN
  } sstate_t;

  sstate_t     state;
  logic [51:0] rad;
  logic [27:0] rem;
  logic [25:0] res;
  logic [4:0]  cnt;

  logic [29:0] rem2;
  logic [29:0] trial;
  logic [29:0] diff;

  always_comb begin
    rem2  = {rem, rad[51:50]};
    trial = {2'd0, res, 2'b01};
    diff  = rem2 - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            rad   <= radicand;
            rem   <= '0;
            res   <= '0;
            cnt   <= 5'(ROOT_STEPS);
            state <= S_ITER;
          end
        end
        S_ITER: begin
          if (rem2 >= trial) begin
            rem <= diff[27:0];
            res <= {res[24:0], 1'b1};
          end else begin
            rem <= rem2[27:0];
            res <= {res[24:0], 1'b0};
          end
          rad <= {rad[49:0], 2'b00};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign done = (state == S_FIN);
  assign root = res;

endmodule

// ----- src/gtm_datapath.sv -----
`timescale 1ns / 1ps

module gtm_datapath import gtm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic signed [15:0] sample,
  input  logic               out_stall,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  output logic [15:0]        magnitude
);

  logic signed [15:0] cos_c;
  logic signed [15:0] sin_c;
  logic [12:0]        blen;

  logic signed [47:0] s1;
  logic signed [47:0] s2;
  logic [12:0]        seen;
  logic signed [15:0] x;

  logic signed [53:0] prod;
  logic [1:0]         prod_k;
  logic signed [64:0] acc;
  logic [25:0]        re8;
  logic [25:0]        im8;

  logic [12:0]        n;
  logic [12:0]        seen_inc;
  logic signed [47:0] src;
  logic signed [26:0] chunk;
  logic signed [26:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [64:0] prod_ext;
  logic signed [64:0] addend;
  logic [47:0]        term;
  logic [47:0]        snew;

  logic               div_done;
  logic [25:0]        quot;
  logic               sqrt_done;
  logic [25:0]        root;

  always_comb begin
    if (blen < BLOCK_MIN) begin
      n = BLOCK_MIN;
    end else if (blen > BLOCK_MAX) begin
      n = BLOCK_MAX;
    end else begin
      n = blen;
    end
    seen_inc = seen + 13'd1;

    src = (cmd.mul_sel == MS_COS_S1) ? s1 : s2;
    case (cmd.mul_k)
      2'd0:    chunk = {11'd0, src[15:0]};
      2'd1:    chunk = {11'd0, src[31:16]};
      default: chunk = {{11{src[47]}}, src[47:32]};
    endcase

    case (cmd.mul_sel)
      MS_COS_S1, MS_COS_S2: begin
        mul_a = {{11{cos_c[15]}}, cos_c};
        mul_b = chunk;
      end
      MS_SIN_S2: begin
        mul_a = {{11{sin_c[15]}}, sin_c};
        mul_b = chunk;
      end
      MS_RE_SQ: begin
        mul_a = {1'b0, re8};
        mul_b = {1'b0, re8};
      end
      default: begin
        mul_a = {1'b0, im8};
        mul_b = {1'b0, im8};
      end
    endcase

    prod_ext = {{11{prod[53]}}, prod};
    case (prod_k)
      2'd0:    addend = prod_ext;
      2'd1:    addend = {prod_ext[48:0], 16'd0};
      default: addend = {prod_ext[32:0], 32'd0};
    endcase

    // round half up, then divide by 8192
    term = acc[60:13] + {47'd0, acc[12]};
    snew = {{32{x[15]}}, x} + term - s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_c <= COS_RESET;
      sin_c <= SIN_RESET;
      blen  <= BLOCK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COS:   cos_c <= cfg_data;
        CFG_SIN:   sin_c <= cfg_data;
        CFG_BLOCK: blen  <= cfg_data[12:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= '0;
      s2   <= '0;
      seen <= '0;
    end else if (cmd.out_load) begin
      s1   <= '0;
      s2   <= '0;
      seen <= '0;
    end else if (cmd.update) begin
      s2   <= s1;
      s1   <= snew;
      seen <= seen_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x <= sample;
    end
    prod   <= mul_a * mul_b;
    prod_k <= cmd.mul_k;
    case (cmd.acc_op)
      ACC_CLEAR:   acc <= '0;
      ACC_LOAD_S1: acc <= {{3{s1[47]}}, s1, 14'd0};
      ACC_ADD:     acc <= acc + addend;
      ACC_SUB:     acc <= acc - addend;
      default:     ;
    endcase
    if (cmd.store_re) begin
      re8 <= quot;
    end
    if (cmd.store_im) begin
      im8 <= quot;
    end
  end

  gtm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc),
    .divisor  (n),
    .done     (div_done),
    .quotient (quot)
  );

  gtm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (acc[51:0]),
    .done     (sqrt_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      magnitude <= (root[25:24] != 2'd0) ? 16'hFFFF : root[23:8];
    end
  end

  always_comb begin
    sts.last      = (seen_inc >= n);
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
    sts.out_free  = !out_valid || !out_stall;
  end

endmodule

// ----- src/gtm_ctrl.sv -----
`timescale 1ns / 1ps

module gtm_ctrl import gtm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_stall,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE,
    MUL,
    MTAIL,
    UPDATE,
    DIV_START,
    DIV_WAIT,
    SQ0,
    SQ1,
    SQ2,
    SQRT_START,
    SQRT_WAIT,
    OUTPUT
  } state_t;

  typedef enum logic [1:0] {
    PH_RECUR,
    PH_RE,
    PH_IM
  } phase_t;

  state_t     state;
  phase_t     phase;
  logic [1:0] k;

  mul_sel_t   phase_sel;
  acc_op_t    acc_init;
  acc_op_t    acc_step;

  always_comb begin
    case (phase)
      PH_RE: begin
        phase_sel = MS_COS_S2;
        acc_init  = ACC_LOAD_S1;
        acc_step  = ACC_SUB;
      end
      PH_IM: begin
        phase_sel = MS_SIN_S2;
        acc_init  = ACC_CLEAR;
        acc_step  = ACC_ADD;
      end
      default: begin
        phase_sel = MS_COS_S1;
        acc_init  = ACC_CLEAR;
        acc_step  = ACC_ADD;
      end
    endcase

    cmd.load_x     = 1'b0;
    cmd.mul_sel    = phase_sel;
    cmd.mul_k      = 2'd0;
    cmd.acc_op     = ACC_HOLD;
    cmd.update     = 1'b0;
    cmd.div_start  = 1'b0;
    cmd.store_re   = 1'b0;
    cmd.store_im   = 1'b0;
    cmd.sqrt_start = 1'b0;
    cmd.out_load   = 1'b0;

    case (state)
      IDLE: begin
        cmd.load_x = in_valid;
      end
      MUL: begin
        cmd.mul_k  = k;
        cmd.acc_op = (k == 2'd0) ? acc_init : acc_step;
      end
      MTAIL: begin
        cmd.acc_op = acc_step;
      end
      UPDATE: begin
        cmd.update = 1'b1;
      end
      DIV_START: begin
        cmd.div_start = 1'b1;
      end
      DIV_WAIT: begin
        cmd.store_re = sts.div_done && (phase == PH_RE);
        cmd.store_im = sts.div_done && (phase == PH_IM);
      end
      SQ0: begin
        cmd.mul_sel = MS_RE_SQ;
        cmd.acc_op  = ACC_CLEAR;
      end
      SQ1: begin
        cmd.mul_sel = MS_IM_SQ;
        cmd.acc_op  = ACC_ADD;
      end
      SQ2: begin
        cmd.acc_op = ACC_ADD;
      end
      SQRT_START: begin
        cmd.sqrt_start = 1'b1;
      end
      OUTPUT: begin
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      phase <= PH_RECUR;
      k     <= 2'd0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            phase <= PH_RECUR;
            k     <= 2'd0;
            state <= MUL;
          end
        end
        MUL: begin
          k <= k + 2'd1;
          if (k == 2'd2) begin
            state <= MTAIL;
          end
        end
        MTAIL: begin
          state <= (phase == PH_RECUR) ? UPDATE : DIV_START;
        end
        UPDATE: begin
          if (sts.last) begin
            phase <= PH_RE;
            k     <= 2'd0;
            state <= MUL;
          end else begin
            state <= IDLE;
          end
        end
        DIV_START: begin
          state <= DIV_WAIT;
        end
        DIV_WAIT: begin
          if (sts.div_done) begin
            if (phase == PH_RE) begin
              phase <= PH_IM;
              k     <= 2'd0;
              state <= MUL;
            end else begin
              state <= SQ0;
            end
          end
        end
        SQ0: begin
          state <= SQ1;
        end
        SQ1: begin
          state <= SQ2;
        end
        SQ2: begin
          state <= SQRT_START;
        end
        SQRT_START: begin
          state <= SQRT_WAIT;
        end
        SQRT_WAIT: begin
          if (sts.sqrt_done) begin
            state <= OUTPUT;
          end
        end
        OUTPUT: begin
          if (sts.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign in_stall = (state != IDLE);

endmodule

// ----- src/goertzel_tone_magnitude.sv -----
// Single-bin Goertzel tone detector. Signed 16-bit samples enter one per
// transaction; each sample is worked through the three partial products
// of the 48-bit recurrence state through one shared 27x27 multiplier plus
// accumulate and state update before the next sample is taken. After the
// sample that completes a block (block_length, clamped to 2..4096), the
// real and imaginary parts each go through the shared multiplier and a
// bit-serial divider, then a 26-step square root. One magnitude per block
// leaves through an output register, so the next block's samples are taken
// while a result waits. Write cos_coeff and sin_coeff in Q1.14 and
// block_length only while the block is idle.
`timescale 1ns / 1ps

module goertzel_tone_magnitude import gtm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        magnitude
);

  cmd_t cmd;
  sts_t sts;

  gtm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  gtm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .magnitude (magnitude)
  );

endmodule
